// ===== hdl/keyed_record_table_unit_defines.svh =====
// assertion macros for the keyed record table unit
// expects clk_i and rst_ni in the scope of each use
`ifndef KEYED_RECORD_TABLE_UNIT_DEFINES_SVH
`define KEYED_RECORD_TABLE_UNIT_DEFINES_SVH

// property must hold at every clock edge out of reset
`define KRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define KRT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/krt_pkg.sv =====
// shared types and constants of the keyed record table unit
// no dependencies
package krt_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int KEY_W    = 31;
  localparam int YEAR_W   = 16;
  localparam int COURSE_W = 16;
  localparam int GRADE_W  = 7;
  localparam int USED_W   = 5;
  localparam logic [GRADE_W-1:0] GRADE_MAX = 7'd100;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_INVALID = 3'd4
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [YEAR_W-1:0]   year;
    logic [COURSE_W-1:0] course_a;
    logic [GRADE_W-1:0]  grade_a;
    logic [COURSE_W-1:0] course_b;
    logic [GRADE_W-1:0]  grade_b;
    logic [COURSE_W-1:0] course_c;
    logic [GRADE_W-1:0]  grade_c;
  } rec_t;

  typedef struct packed {
    status_e            status;
    logic [USED_W-1:0]  used_count;
    rec_t               rec;
    logic               last;
  } result_t;

endpackage

// ===== hdl/keyed_record_table_unit.sv =====
// channel | dir | handshake               | payload
// in      | in  | in_valid_i / in_ready_o | op, key, year, three course/grade pairs
// out     | out | out_valid_o/out_ready_i | status, used_count, found record, last
//
// add (when not full, key nonzero), delete and read scan the stored keys one entry per
// cycle through the record ram read port; delete then shifts later entries down at one
// entry per cycle; list reads then emits each key, waiting on a full result register.
// reset clears the entry count only, the ram contents are not cleared.
// one result register parts the sides; a full register that is not taken stalls
// the sequencer, and a new transfer is taken once the last result is in the register.
// depends on krt_pkg, krt_ram, krt_engine and keyed_record_table_unit_defines.svh
`include "keyed_record_table_unit_defines.svh"

module keyed_record_table_unit import krt_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [YEAR_W-1:0]   year_i,
  input  logic [COURSE_W-1:0] first_course_i,
  input  logic [GRADE_W-1:0]  first_grade_i,
  input  logic [COURSE_W-1:0] second_course_i,
  input  logic [GRADE_W-1:0]  second_grade_i,
  input  logic [COURSE_W-1:0] third_course_i,
  input  logic [GRADE_W-1:0]  third_grade_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [USED_W-1:0]   used_count_o,
  output logic [KEY_W-1:0]    found_key_o,
  output logic [YEAR_W-1:0]   found_year_o,
  output logic [COURSE_W-1:0] found_course_a_o,
  output logic [GRADE_W-1:0]  found_grade_a_o,
  output logic [COURSE_W-1:0] found_course_b_o,
  output logic [GRADE_W-1:0]  found_grade_b_o,
  output logic [COURSE_W-1:0] found_course_c_o,
  output logic [GRADE_W-1:0]  found_grade_c_o,
  output logic                last_o
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  rec_t             in_rec;
  logic             slot_free;
  logic             push;
  result_t          res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rec_t             ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  rec_t             ram_rdata;
  logic             out_valid_q, out_valid_d;
  result_t          out_res_q, out_res_d;

  always_comb begin
    in_rec.key      = key_i;
    in_rec.year     = year_i;
    in_rec.course_a = first_course_i;
    in_rec.grade_a  = first_grade_i;
    in_rec.course_b = second_course_i;
    in_rec.grade_b  = second_grade_i;
    in_rec.course_c = third_course_i;
    in_rec.grade_c  = third_grade_i;
  end

  krt_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (CAPACITY)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  krt_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .rec_i       (in_rec),
    .slot_free_i (slot_free),
    .push_o      (push),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // result register, refilled in the cycle it is taken
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_res_q.status;
  assign used_count_o     = out_res_q.used_count;
  assign found_key_o      = out_res_q.rec.key;
  assign found_year_o     = out_res_q.rec.year;
  assign found_course_a_o = out_res_q.rec.course_a;
  assign found_grade_a_o  = out_res_q.rec.grade_a;
  assign found_course_b_o = out_res_q.rec.course_b;
  assign found_grade_b_o  = out_res_q.rec.grade_b;
  assign found_course_c_o = out_res_q.rec.course_c;
  assign found_grade_c_o  = out_res_q.rec.grade_c;
  assign last_o           = out_res_q.last;

  `KRT_ASSERT_NEVER(a_no_overwrite, push && out_valid_q && !out_ready_i, "result overwritten")
  `KRT_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `KRT_ASSERT(a_error_is_last, (out_valid_o && (status_o != ST_OK)) |-> last_o, "error not last")
  `KRT_ASSERT(a_error_no_key, (out_valid_o && (status_o != ST_OK)) |-> (found_key_o == '0), "key on error")

endmodule

// ===== hdl/krt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/krt_engine.sv =====
// operation sequencer: key scan, append, compacting delete and key listing
// depends on krt_pkg; drives the record ram held in the top level
module krt_engine import krt_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  rec_t             rec_i,
  input  logic             slot_free_i,
  output logic             push_o,
  output result_t          res_o,
  output logic             ram_we_o,
  output logic [IDX_W-1:0] ram_waddr_o,
  output rec_t             ram_wdata_o,
  output logic             ram_re_o,
  output logic [IDX_W-1:0] ram_raddr_o,
  input  rec_t             ram_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST_RD,
    S_LIST_OUT,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  rec_t             rec_q, rec_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] cmp_q, cmp_d;
  logic             pend_q, pend_d;
  result_t          res_q, res_d;

  logic             hit;
  logic             issue;
  logic             full;
  logic [CNT_W-1:0] ptr_inc;
  logic [CNT_W-1:0] shift_dst;
  logic             list_last;

  function automatic logic fields_ok(rec_t r);
    logic ok;
    ok = (r.year != '0) && (r.course_a != '0) && (r.course_b != '0) &&
         (r.course_c != '0) && (r.grade_a <= GRADE_MAX) &&
         (r.grade_b <= GRADE_MAX) && (r.grade_c <= GRADE_MAX);
    return ok;
  endfunction

  // compare uses the entry read in the previous cycle
  assign hit       = pend_q && (ram_rdata_i.key == rec_q.key);
  assign issue     = ptr_q < count_q;
  assign full      = count_q == CNT_W'(CAPACITY);
  assign ptr_inc   = ptr_q + CNT_W'(1);
  assign shift_dst = cmp_q - CNT_W'(1);
  assign list_last = ptr_inc == count_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    rec_d       = rec_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    cmp_d       = cmp_q;
    pend_d      = 1'b0;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = shift_dst[IDX_W-1:0];
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = ptr_q[IDX_W-1:0];
    push_o      = 1'b0;
    res_o       = res_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_e'(op_i);
          rec_d      = rec_i;
          ptr_d      = '0;
          res_d      = '0;
          res_d.last = 1'b1;
          case (op_e'(op_i))
            OP_ADD: begin
              if (full) begin
                res_d.status = ST_FULL;
                state_d      = S_EMIT;
              end else if (rec_i.key == '0) begin
                res_d.status = ST_INVALID;
                state_d      = S_EMIT;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_DELETE, OP_READ: begin
              state_d = S_SCAN;
            end
            OP_LIST: begin
              state_d = (count_q == '0) ? S_EMIT : S_LIST_RD;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          case (op_q)
            OP_ADD: begin
              res_d.status = ST_DUP;
              state_d      = S_EMIT;
            end
            OP_READ: begin
              res_d.rec = ram_rdata_i;
              state_d   = S_EMIT;
            end
            OP_DELETE: begin
              ptr_d   = cmp_q + CNT_W'(1);
              state_d = S_SHIFT;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end else if (issue) begin
          ram_re_o = 1'b1;
          pend_d   = 1'b1;
          cmp_d    = ptr_q;
          ptr_d    = ptr_inc;
        end else if (!pend_q) begin
          // key not stored
          if (op_q == OP_ADD) begin
            if (fields_ok(rec_q)) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = count_q[IDX_W-1:0];
              ram_wdata_o = rec_q;
              count_d     = count_q + CNT_W'(1);
            end else begin
              res_d.status = ST_INVALID;
            end
          end else begin
            res_d.status = ST_MISSING;
          end
          state_d = S_EMIT;
        end
      end

      S_SHIFT: begin
        // move the entry read last cycle down one place
        if (pend_q) begin
          ram_we_o = 1'b1;
        end
        if (issue) begin
          ram_re_o = 1'b1;
          pend_d   = 1'b1;
          cmp_d    = ptr_q;
          ptr_d    = ptr_inc;
        end else if (!pend_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_EMIT;
        end
      end

      S_LIST_RD: begin
        ram_re_o = 1'b1;
        state_d  = S_LIST_OUT;
      end

      S_LIST_OUT: begin
        res_o         = '0;
        res_o.rec.key = ram_rdata_i.key;
        res_o.last    = list_last;
        push_o        = slot_free_i;
        if (slot_free_i) begin
          if (list_last) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_inc;
            state_d = S_LIST_RD;
          end
        end
      end

      S_EMIT: begin
        push_o = slot_free_i;
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o.used_count = USED_W'(count_q);
  end

  assign in_ready_o = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ADD;
      rec_q   <= '0;
      count_q <= '0;
      ptr_q   <= '0;
      cmp_q   <= '0;
      pend_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      rec_q   <= rec_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      cmp_q   <= cmp_d;
      pend_q  <= pend_d;
      res_q   <= res_d;
    end
  end

endmodule

// ===== tb/keyed_record_table_unit_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench of keyed_record_table_unit: directed and random add, delete,
// read and list traffic checked against a record table predictor, with random stalls
// depends on krt_pkg and the keyed_record_table_unit rtl
module keyed_record_table_unit_test;
  import krt_pkg::*;

  localparam int TABLE_DEPTH     = 16;
  localparam int KEY_POOL_SIZE   = 24;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          op_i;
  logic [KEY_W-1:0]    key_i;
  logic [YEAR_W-1:0]   year_i;
  logic [COURSE_W-1:0] first_course_i;
  logic [GRADE_W-1:0]  first_grade_i;
  logic [COURSE_W-1:0] second_course_i;
  logic [GRADE_W-1:0]  second_grade_i;
  logic [COURSE_W-1:0] third_course_i;
  logic [GRADE_W-1:0]  third_grade_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [2:0]          status_o;
  logic [USED_W-1:0]   used_count_o;
  logic [KEY_W-1:0]    found_key_o;
  logic [YEAR_W-1:0]   found_year_o;
  logic [COURSE_W-1:0] found_course_a_o;
  logic [GRADE_W-1:0]  found_grade_a_o;
  logic [COURSE_W-1:0] found_course_b_o;
  logic [GRADE_W-1:0]  found_grade_b_o;
  logic [COURSE_W-1:0] found_course_c_o;
  logic [GRADE_W-1:0]  found_grade_c_o;
  logic                last_o;

  // predictor state: stored records in insertion order, results still to arrive
  rec_t             stored_recs_q[$];
  result_t          pending_results_q[$];
  logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];

  int error_count;
  int item_count;
  int result_count;
  int full_hits;
  int op_count[4];
  int rx_stall;
  int idle_cycles;
  bit bursty;
  bit hold_off_req;

  keyed_record_table_unit #(.CAPACITY(TABLE_DEPTH)) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .key_i            (key_i),
    .year_i           (year_i),
    .first_course_i   (first_course_i),
    .first_grade_i    (first_grade_i),
    .second_course_i  (second_course_i),
    .second_grade_i   (second_grade_i),
    .third_course_i   (third_course_i),
    .third_grade_i    (third_grade_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .used_count_o     (used_count_o),
    .found_key_o      (found_key_o),
    .found_year_o     (found_year_o),
    .found_course_a_o (found_course_a_o),
    .found_grade_a_o  (found_grade_a_o),
    .found_course_b_o (found_course_b_o),
    .found_grade_b_o  (found_grade_b_o),
    .found_course_c_o (found_course_c_o),
    .found_grade_c_o  (found_grade_c_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones, none during a burst stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (bursty || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom());
    if (k == '0) k = KEY_W'(1);
    return k;
  endfunction

  function automatic rec_t good_record(logic [KEY_W-1:0] key);
    rec_t r;
    r.key      = key;
    r.year     = YEAR_W'($urandom_range(1, 16'hFFFF));
    r.course_a = COURSE_W'($urandom_range(1, 16'hFFFF));
    r.course_b = COURSE_W'($urandom_range(1, 16'hFFFF));
    r.course_c = COURSE_W'($urandom_range(1, 16'hFFFF));
    r.grade_a  = GRADE_W'($urandom_range(0, GRADE_MAX));
    r.grade_b  = GRADE_W'($urandom_range(0, GRADE_MAX));
    r.grade_c  = GRADE_W'($urandom_range(0, GRADE_MAX));
    return r;
  endfunction

  function automatic rec_t spoil_record(rec_t r);
    case ($urandom_range(0, 6))
      0: r.year = '0;
      1: r.course_a = '0;
      2: r.course_b = '0;
      3: r.course_c = '0;
      4: r.grade_a = GRADE_W'($urandom_range(GRADE_MAX + 1, 127));
      5: r.grade_b = GRADE_W'($urandom_range(GRADE_MAX + 1, 127));
      default: r.grade_c = GRADE_W'($urandom_range(GRADE_MAX + 1, 127));
    endcase
    return r;
  endfunction

  // key for delete or read: mostly a stored one, else pool, zero or random
  function automatic logic [KEY_W-1:0] lookup_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60 && stored_recs_q.size() > 0)
      return stored_recs_q[$urandom_range(0, stored_recs_q.size() - 1)].key;
    if (r < 90) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    if (r < 95) return '0;
    return fresh_key();
  endfunction

  // updates the record table for one accepted op and queues its results
  function automatic void predict_table_op(op_e op, rec_t item);
    int      pos;
    result_t res;
    pos = -1;
    foreach (stored_recs_q[i])
      if (pos < 0 && stored_recs_q[i].key == item.key) pos = i;
    res        = '0;
    res.status = ST_OK;
    case (op)
      OP_ADD: begin
        if (stored_recs_q.size() >= TABLE_DEPTH) begin
          res.status = ST_FULL;
          full_hits++;
        end else if (item.key == '0) begin
          res.status = ST_INVALID;
        end else if (pos >= 0) begin
          res.status = ST_DUP;
        end else if (item.year == '0 || item.course_a == '0 || item.course_b == '0 ||
                     item.course_c == '0 || item.grade_a > GRADE_MAX ||
                     item.grade_b > GRADE_MAX || item.grade_c > GRADE_MAX) begin
          res.status = ST_INVALID;
        end else begin
          stored_recs_q.push_back(item);
        end
      end
      OP_DELETE: begin
        if (pos < 0) res.status = ST_MISSING;
        else stored_recs_q.delete(pos);
      end
      OP_READ: begin
        if (pos < 0) res.status = ST_MISSING;
        else res.rec = stored_recs_q[pos];
      end
      default: begin
        // one result per stored key, last flag on the final one
        if (stored_recs_q.size() > 0) begin
          foreach (stored_recs_q[i]) begin
            res.rec        = '0;
            res.rec.key    = stored_recs_q[i].key;
            res.used_count = USED_W'(stored_recs_q.size());
            res.last       = (i == stored_recs_q.size() - 1);
            pending_results_q.push_back(res);
          end
          return;
        end
      end
    endcase
    res.used_count = USED_W'(stored_recs_q.size());
    res.last       = 1'b1;
    pending_results_q.push_back(res);
  endfunction

  task automatic send_item(op_e op, rec_t item);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i            = op;
    key_i           = item.key;
    year_i          = item.year;
    first_course_i  = item.course_a;
    first_grade_i   = item.grade_a;
    second_course_i = item.course_b;
    second_grade_i  = item.grade_b;
    third_course_i  = item.course_c;
    third_grade_i   = item.grade_c;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_table_op(op, item);
    item_count++;
    op_count[op]++;
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // result checker
  initial begin
    result_t exp_res;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        result_count++;
        if (pending_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0h key %0h",
                   $time, status_o, found_key_o);
          error_count++;
        end else begin
          exp_res = pending_results_q.pop_front();
          check_field("status", exp_res.status, status_o);
          check_field("used_count", exp_res.used_count, used_count_o);
          check_field("found_key", exp_res.rec.key, found_key_o);
          check_field("found_year", exp_res.rec.year, found_year_o);
          check_field("found_course_a", exp_res.rec.course_a, found_course_a_o);
          check_field("found_grade_a", exp_res.rec.grade_a, found_grade_a_o);
          check_field("found_course_b", exp_res.rec.course_b, found_course_b_o);
          check_field("found_grade_b", exp_res.rec.grade_b, found_grade_b_o);
          check_field("found_course_c", exp_res.rec.course_c, found_course_c_o);
          check_field("found_grade_c", exp_res.rec.grade_c, found_grade_c_o);
          check_field("last", exp_res.last, last_o);
        end
      end
    end
  end

  // result side: random stalls, and one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    rx_stall    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (rx_stall > 0) begin
        out_ready_i = 1'b0;
        rx_stall--;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 99) < 30) rx_stall = pick_gap();
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, idle_cycles, pending_results_q.size());
    $display("** keyed_record_table_unit: FAILED **");
    $finish;
  end

  task automatic test_empty_table();
    send_item(OP_LIST, good_record('0));
    send_item(OP_READ, good_record(31'd5));
    send_item(OP_DELETE, good_record(31'd5));
    send_item(OP_READ, good_record('0));
    send_item(OP_DELETE, good_record('0));
  endtask

  task automatic test_add_checks();
    rec_t r;
    send_item(OP_ADD, good_record('0));
    r         = '1;
    r.grade_a = GRADE_MAX;
    r.grade_b = GRADE_MAX;
    r.grade_c = GRADE_MAX;
    send_item(OP_ADD, r);
    r          = '0;
    r.key      = KEY_W'(1);
    r.year     = YEAR_W'(1);
    r.course_a = COURSE_W'(1);
    r.course_b = COURSE_W'(1);
    r.course_c = COURSE_W'(1);
    send_item(OP_ADD, r);
    // duplicate key wins over a bad field
    r.year = '0;
    send_item(OP_ADD, r);
    r      = good_record(31'd2);
    r.year = '0;
    send_item(OP_ADD, r);
    r          = good_record(31'd3);
    r.course_a = '0;
    send_item(OP_ADD, r);
    r          = good_record(31'd4);
    r.course_b = '0;
    send_item(OP_ADD, r);
    r          = good_record(31'd5);
    r.course_c = '0;
    send_item(OP_ADD, r);
    r         = good_record(31'd6);
    r.grade_b = GRADE_W'(GRADE_MAX + 1);
    send_item(OP_ADD, r);
    r         = good_record(31'd7);
    r.grade_a = '1;
    r.grade_b = '1;
    r.grade_c = '1;
    send_item(OP_ADD, r);
  endtask

  task automatic test_read_delete();
    send_item(OP_READ, good_record('1));
    send_item(OP_READ, good_record(31'd1));
    // removing the first entry moves the rest down
    send_item(OP_DELETE, good_record('1));
    send_item(OP_READ, good_record(31'd1));
    send_item(OP_READ, good_record('1));
    send_item(OP_ADD, good_record(31'h2AAA_AAAA));
    send_item(OP_ADD, good_record(31'h5555_5555));
    send_item(OP_LIST, good_record('0));
    send_item(OP_DELETE, good_record(31'd1));
    send_item(OP_READ, good_record(31'h5555_5555));
    send_item(OP_LIST, good_record('0));
  endtask

  task automatic test_random_traffic(int count);
    int   r;
    int   kr;
    rec_t rec;
    foreach (key_pool[i]) key_pool[i] = fresh_key();
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) bursty = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        kr  = $urandom_range(0, 99);
        rec = good_record(kr < 85 ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] :
                          kr < 95 ? fresh_key() : '0);
        if ($urandom_range(0, 99) < 15) rec = spoil_record(rec);
        send_item(OP_ADD, rec);
      end else if (r < 65) begin
        send_item(OP_DELETE, good_record(lookup_key()));
      end else if (r < 90) begin
        send_item(OP_READ, good_record(lookup_key()));
      end else begin
        send_item(OP_LIST, good_record(fresh_key()));
      end
    end
    bursty = 1'b0;
  endtask

  // a result held behind a stalled receiver stalls the sequencer and then the input
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    send_item(OP_LIST, good_record('0));
    send_item(OP_READ, good_record(lookup_key()));
    send_item(OP_LIST, good_record('0));
    repeat (11) begin
      if ($urandom_range(0, 1) == 0) send_item(OP_ADD, good_record(fresh_key()));
      else send_item(OP_READ, good_record(lookup_key()));
    end
  endtask

  task automatic test_fill_and_drain();
    rec_t rec;
    int   pos;
    while (stored_recs_q.size() < TABLE_DEPTH) begin
      rec = good_record(fresh_key());
      if ($urandom_range(0, 9) == 0) rec = spoil_record(rec);
      send_item(OP_ADD, rec);
    end
    // a full table refuses before any other check
    send_item(OP_ADD, good_record(fresh_key()));
    send_item(OP_ADD, good_record('0));
    send_item(OP_ADD, good_record(stored_recs_q[0].key));
    send_item(OP_ADD, spoil_record(good_record(fresh_key())));
    send_item(OP_LIST, good_record('0));
    send_item(OP_READ, good_record(stored_recs_q[TABLE_DEPTH - 1].key));
    while (stored_recs_q.size() > 0) begin
      pos = $urandom_range(0, stored_recs_q.size() - 1);
      send_item(OP_DELETE, good_record(stored_recs_q[pos].key));
      if ($urandom_range(0, 3) == 0) send_item(OP_LIST, good_record(fresh_key()));
      else if ($urandom_range(0, 3) == 0) send_item(OP_READ, good_record(lookup_key()));
    end
    send_item(OP_LIST, good_record('0));
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    op_i            = OP_ADD;
    key_i           = '0;
    year_i          = '0;
    first_course_i  = '0;
    first_grade_i   = '0;
    second_course_i = '0;
    second_grade_i  = '0;
    third_course_i  = '0;
    third_grade_i   = '0;
    bursty          = 1'b0;
    hold_off_req    = 1'b0;
    error_count     = 0;
    item_count      = 0;
    result_count    = 0;
    full_hits       = 0;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_add_checks();
    test_read_delete();
    test_random_traffic(150);
    test_backpressure();
    test_fill_and_drain();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d input transfers (%0d add, %0d delete, %0d read, %0d list)",
             item_count, op_count[OP_ADD], op_count[OP_DELETE], op_count[OP_READ],
             op_count[OP_LIST]);
    $display("checked %0d results, %0d adds hit a full table, %0d mismatches",
             result_count, full_hits, error_count);
    if (error_count == 0)
      $display("** keyed_record_table_unit: PASSED **");
    else
      $display("** keyed_record_table_unit: FAILED **");
    $finish;
  end

endmodule
